>>> src/vdi_pkg.sv
// ----------------------------------------------------------------------------
// vdi_pkg
// Shared types for the vertex deduplication indexer: request and result
// payloads, the key word, the chain carry and the controller states.
// ----------------------------------------------------------------------------
package vdi_pkg;

	localparam int KEY_W = 256;

	typedef logic [KEY_W-1:0] key_t;

	// One vertex request
	typedef struct packed {
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
		logic [31:0] tex_u;
		logic [31:0] tex_v;
		logic [31:0] norm_x;
		logic [31:0] norm_y;
		logic [31:0] norm_z;
		logic        start_mesh;
	} in_t;

	// One lookup result
	typedef struct packed {
		logic [7:0] vertex_index;
		logic       is_new;
		logic       table_full;
	} out_t;

	// Search token handed from cell to cell
	typedef struct packed {
		logic active;
		logic found;
	} carry_t;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SEARCH = 3'b010,
		ST_DONE   = 3'b100
	} state_t;

endpackage

>>> src/vertex_dedup_indexer.sv
// ----------------------------------------------------------------------------
// vertex_dedup_indexer
// Vertex deduplication for index buffer construction, built as a chain of
// key cells searched by a token that walks one cell per cycle.
// ----------------------------------------------------------------------------
// Each request carries one vertex of eight raw 32-bit words and a start-of-mesh
// flag. The key table is a row of MAX_VERTICES cells. A search token enters
// the first cell and steps one cell per clock. The block works on one
// vertex at a time; the next vertex is accepted only after the previous
// one has retired, and retiring waits while the output register still
// holds a result that has not been taken. The result sits in an output
// register, so the next vertex is taken while an earlier result still waits
// downstream. A hit returns the stored index; a miss appends the key and
// returns its index with is_new set; a miss on a full table returns index 0
// with table_full set. Keys compare bit for bit. Indexes wider than 8 bits
// are reported by their low 8 bits.
// ----------------------------------------------------------------------------
module vertex_dedup_indexer #(
	parameter int MAX_VERTICES = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  vdi_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output vdi_pkg::out_t out_data
);

	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int IDX_W = $clog2(MAX_VERTICES);
	localparam int EXT_W = (CNT_W > 8) ? CNT_W : 8;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_VERTICES);

	vdi_pkg::state_t  state_q;
	vdi_pkg::key_t    query_q;
	logic [CNT_W-1:0] count_q;
	logic             inject_q;
	logic             res_found_q;
	logic [IDX_W-1:0] res_idx_q;
	logic             out_valid_q;
	vdi_pkg::out_t    out_data_q;

	vdi_pkg::carry_t  carry [MAX_VERTICES+1];
	logic [IDX_W-1:0] idx   [MAX_VERTICES+1];

	logic             accept;
	logic             out_free;
	logic             retire;
	logic             table_full;
	logic             do_write;
	logic [EXT_W-1:0] hit_ext;
	logic [EXT_W-1:0] cnt_ext;

	assign in_ready = (state_q == vdi_pkg::ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign retire   = (state_q == vdi_pkg::ST_DONE) && out_free;

	assign table_full = (count_q == FULL_CNT);
	assign do_write   = retire && !res_found_q && !table_full;

	// Inject the token at the head of the chain
	assign carry[0].active = inject_q;
	assign carry[0].found  = 1'b0;
	assign idx[0]          = '0;

	genvar gi;
	generate
		for (gi = 0; gi < MAX_VERTICES; gi++) begin : g_cell
			vdi_cell #(
				.CNT_W(CNT_W),
				.IDX_W(IDX_W),
				.INDEX(gi)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.query    (query_q),
				.count    (count_q),
				.wr_en    (do_write),
				.carry_in (carry[gi]),
				.idx_in   (idx[gi]),
				.carry_out(carry[gi+1]),
				.idx_out  (idx[gi+1])
			);
		end
	endgenerate

	// Hold the query for the whole walk
	always_ff @(posedge clk) begin
		if (accept) begin
			query_q <= {in_data.pos_x, in_data.pos_y, in_data.pos_z,
				in_data.tex_u, in_data.tex_v,
				in_data.norm_x, in_data.norm_y, in_data.norm_z};
		end
	end

	// Capture the token as it leaves the last cell
	always_ff @(posedge clk) begin
		if (carry[MAX_VERTICES].active) begin
			res_found_q <= carry[MAX_VERTICES].found;
			res_idx_q   <= idx[MAX_VERTICES];
		end
	end

	// Sequence: accept, walk the chain, retire into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= vdi_pkg::ST_IDLE;
			count_q  <= '0;
			inject_q <= 1'b0;
		end else begin
			inject_q <= accept;
			case (state_q)
				vdi_pkg::ST_IDLE: begin
					if (accept) begin
						if (in_data.start_mesh) begin
							count_q <= '0;
						end
						state_q <= vdi_pkg::ST_SEARCH;
					end
				end
				vdi_pkg::ST_SEARCH: begin
					if (carry[MAX_VERTICES].active) begin
						state_q <= vdi_pkg::ST_DONE;
					end
				end
				vdi_pkg::ST_DONE: begin
					if (out_free) begin
						if (do_write) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= vdi_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= vdi_pkg::ST_IDLE;
				end
			endcase
		end
	end

	assign hit_ext = EXT_W'(res_idx_q);
	assign cnt_ext = EXT_W'(count_q);

	// Output register: load on retire, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (retire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (retire) begin
			if (res_found_q) begin
				out_data_q.vertex_index <= hit_ext[7:0];
				out_data_q.is_new       <= 1'b0;
				out_data_q.table_full   <= 1'b0;
			end else if (table_full) begin
				out_data_q.vertex_index <= '0;
				out_data_q.is_new       <= 1'b0;
				out_data_q.table_full   <= 1'b1;
			end else begin
				out_data_q.vertex_index <= cnt_ext[7:0];
				out_data_q.is_new       <= 1'b1;
				out_data_q.table_full   <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

>>> src/vdi_cell.sv
// ----------------------------------------------------------------------------
// vdi_cell
// One table entry: holds a stored key, compares it against the broadcast
// query when the search token passes, and hands the token to its neighbor.
// ----------------------------------------------------------------------------
module vdi_cell #(
	parameter int CNT_W = 9,
	parameter int IDX_W = 8,
	parameter int INDEX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  vdi_pkg::key_t       query,
	input  logic [CNT_W-1:0]    count,
	input  logic                wr_en,
	input  vdi_pkg::carry_t     carry_in,
	input  logic [IDX_W-1:0]    idx_in,
	output vdi_pkg::carry_t     carry_out,
	output logic [IDX_W-1:0]    idx_out
);

	localparam logic [CNT_W-1:0] SLOT = CNT_W'(INDEX);
	localparam logic [IDX_W-1:0] SLOT_IDX = IDX_W'(INDEX);

	vdi_pkg::key_t   key_q;
	vdi_pkg::carry_t carry_q;
	logic [IDX_W-1:0] idx_q;
	logic             hit;

	// Match only a live entry, and only the first one along the chain
	assign hit = carry_in.active && !carry_in.found && (SLOT < count) && (key_q == query);

	// Store the query when this slot is the next free one
	always_ff @(posedge clk) begin
		if (wr_en && (count == SLOT)) begin
			key_q <= query;
		end
	end

	// Advance the token one cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= '0;
		end else begin
			carry_q.active <= carry_in.active;
			carry_q.found  <= carry_in.found | hit;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= hit ? SLOT_IDX : idx_in;
	end

	assign carry_out = carry_q;
	assign idx_out   = idx_q;

endmodule
